[design/bpt_pkg.sv]
// Package for the Bezier path tessellator: beat types, t table and microcode.
// Used by bpt_lane and bezier_path_tessellator; depends on nothing.
package bpt_pkg;

  localparam int STEPS = 30;
  localparam int J_W = $clog2(STEPS + 1);
  localparam int T_W = 17;
  localparam int PC_W = 3;

  typedef struct packed {
    logic               first_point;
    logic signed [15:0] knot_x;
    logic signed [15:0] knot_y;
    logic signed [15:0] in_handle_x;
    logic signed [15:0] in_handle_y;
    logic signed [15:0] out_handle_x;
    logic signed [15:0] out_handle_y;
  } knot_t;

  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic               last_sample;
  } sample_t;

  typedef enum logic [3:0] {
    R_P0, R_P1, R_P2, R_P3, R_B1, R_B2, R_B3, R_C1, R_C2
  } reg_sel_t;

  typedef struct packed {
    logic     wr;
    reg_sel_t src_a;
    reg_sel_t src_b;
    reg_sel_t dst;
  } lane_ctl_t;

  typedef struct packed {
    lane_ctl_t lane;
    logic      emit;
  } ucode_t;

  localparam logic [PC_W-1:0] LAST_PC = PC_W'(5);

  typedef logic [T_W-1:0] t_table_t [0:STEPS];

  function automatic t_table_t build_t_table();
    t_table_t tab;
    for (int j = 0; j <= STEPS; j++) begin
      tab[j] = T_W'((j * 2 * 65536 + STEPS) / (2 * STEPS));
    end
    return tab;
  endfunction

  localparam t_table_t T_TABLE = build_t_table();

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{lane: '{wr: 1'b0, src_a: R_C1, src_b: R_C2, dst: R_C2}, emit: 1'b0};
    case (pc)
      3'd0: w.lane = '{wr: 1'b1, src_a: R_P0, src_b: R_P1, dst: R_B1};
      3'd1: w.lane = '{wr: 1'b1, src_a: R_P1, src_b: R_P2, dst: R_B2};
      3'd2: w.lane = '{wr: 1'b1, src_a: R_P2, src_b: R_P3, dst: R_B3};
      3'd3: w.lane = '{wr: 1'b1, src_a: R_B1, src_b: R_B2, dst: R_C1};
      3'd4: w.lane = '{wr: 1'b1, src_a: R_B2, src_b: R_B3, dst: R_C2};
      3'd5: w.emit = 1'b1;
      default: w.emit = 1'b0;
    endcase
    return w;
  endfunction

endpackage

[design/bpt_lane.sv]
// One coordinate lane: control point and partial registers plus a rounding,
// saturating lerp unit. Depends on bpt_pkg.
module bpt_lane (
  input  logic                        clk,
  input  logic                        load,
  input  logic signed [15:0]          p0_in,
  input  logic signed [15:0]          p1_in,
  input  logic signed [15:0]          p2_in,
  input  logic signed [15:0]          p3_in,
  input  bpt_pkg::lane_ctl_t          ctl,
  input  logic                        wr_en,
  input  logic [bpt_pkg::T_W-1:0]     t,
  output logic signed [15:0]          result
);

  logic signed [15:0] p0, p1, p2, p3, b1, b2, b3, c1, c2;
  logic signed [15:0] opa, opb;
  logic signed [16:0] diff;
  logic signed [34:0] prod;
  logic signed [35:0] sum;
  logic signed [19:0] q;

  function automatic logic signed [15:0] pick(
    input bpt_pkg::reg_sel_t s,
    input logic signed [15:0] r0, r1, r2, r3, r4, r5, r6, r7, r8
  );
    logic signed [15:0] v;
    case (s)
      bpt_pkg::R_P0: v = r0;
      bpt_pkg::R_P1: v = r1;
      bpt_pkg::R_P2: v = r2;
      bpt_pkg::R_P3: v = r3;
      bpt_pkg::R_B1: v = r4;
      bpt_pkg::R_B2: v = r5;
      bpt_pkg::R_B3: v = r6;
      bpt_pkg::R_C1: v = r7;
      bpt_pkg::R_C2: v = r8;
      default:       v = r8;
    endcase
    return v;
  endfunction

  always_comb begin
    opa  = pick(ctl.src_a, p0, p1, p2, p3, b1, b2, b3, c1, c2);
    opb  = pick(ctl.src_b, p0, p1, p2, p3, b1, b2, b3, c1, c2);
    diff = 17'(opb) - 17'(opa);
    prod = 35'(diff) * 35'($signed({1'b0, t}));
    sum  = $signed({{4{opa[15]}}, opa, 16'h0000}) + 36'(prod) + 36'sd32768;
    q    = sum[35:16];
    if (q > 20'sd32767) begin
      result = 16'sh7fff;
    end else if (q < -20'sd32768) begin
      result = -16'sh8000;
    end else begin
      result = q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p0 <= p0_in;
      p1 <= p1_in;
      p2 <= p2_in;
      p3 <= p3_in;
    end else if (wr_en) begin
      case (ctl.dst)
        bpt_pkg::R_B1: b1 <= result;
        bpt_pkg::R_B2: b2 <= result;
        bpt_pkg::R_B3: b3 <= result;
        bpt_pkg::R_C1: c1 <= result;
        bpt_pkg::R_C2: c2 <= result;
        default:       c2 <= c2;
      endcase
    end
  end

endmodule

[design/bezier_path_tessellator.sv]
// Cubic Bezier path tessellator: microcoded de Casteljau over two lanes.
// Depends on bpt_pkg and bpt_lane.
// A knot beat is taken while the sequencer is idle; a segment knot then yields STEPS+1 samples.
// Each sample takes six program steps, one lerp per lane per step, so a segment
// keeps the input busy until its last sample is written to the output register,
// including any output stall.
// Knots that start a path, or that have no previous knot, emit nothing.
// Synchronous reset clears the sequencer, the output valid and the previous knot.
module bezier_path_tessellator (
  input  logic             clk,
  input  logic             rst,
  input  logic             knot_valid,
  output logic             knot_ready,
  input  bpt_pkg::knot_t   knot,
  output logic             sample_valid,
  input  logic             sample_ready,
  output bpt_pkg::sample_t sample
);

  logic                      busy;
  logic [bpt_pkg::PC_W-1:0]  pc;
  logic [bpt_pkg::J_W-1:0]   j;
  logic                      have_previous;
  logic signed [15:0]        prev_knot_x, prev_knot_y, prev_out_x, prev_out_y;
  bpt_pkg::ucode_t           uw;
  logic                      accept, advance, last_j;
  logic signed [15:0]        res_x, res_y;
  logic [bpt_pkg::T_W-1:0]   t;

  assign knot_ready = !busy;
  assign accept     = knot_valid && knot_ready;
  assign uw         = bpt_pkg::ucode(pc);
  assign advance    = busy && (!uw.emit || !sample_valid || sample_ready);
  assign last_j     = (j == bpt_pkg::J_W'(bpt_pkg::STEPS));
  assign t          = bpt_pkg::T_TABLE[j];

  bpt_lane u_lane_x (
    .clk    (clk),
    .load   (accept),
    .p0_in  (prev_knot_x),
    .p1_in  (prev_out_x),
    .p2_in  (knot.in_handle_x),
    .p3_in  (knot.knot_x),
    .ctl    (uw.lane),
    .wr_en  (advance && uw.lane.wr),
    .t      (t),
    .result (res_x)
  );

  bpt_lane u_lane_y (
    .clk    (clk),
    .load   (accept),
    .p0_in  (prev_knot_y),
    .p1_in  (prev_out_y),
    .p2_in  (knot.in_handle_y),
    .p3_in  (knot.knot_y),
    .ctl    (uw.lane),
    .wr_en  (advance && uw.lane.wr),
    .t      (t),
    .result (res_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      pc            <= '0;
      j             <= '0;
      have_previous <= 1'b0;
      prev_knot_x   <= '0;
      prev_knot_y   <= '0;
      prev_out_x    <= '0;
      prev_out_y    <= '0;
      sample_valid  <= 1'b0;
    end else begin
      if (advance && uw.emit) begin
        sample_valid <= 1'b1;
      end else if (sample_valid && sample_ready) begin
        sample_valid <= 1'b0;
      end
      if (accept) begin
        have_previous <= 1'b1;
        prev_knot_x   <= knot.knot_x;
        prev_knot_y   <= knot.knot_y;
        prev_out_x    <= knot.out_handle_x;
        prev_out_y    <= knot.out_handle_y;
        busy          <= !knot.first_point && have_previous;
        pc            <= '0;
        j             <= '0;
      end else if (advance) begin
        if (uw.emit) begin
          sample       <= '{sample_x: res_x, sample_y: res_y, last_sample: last_j};
          pc           <= '0;
          if (last_j) begin
            busy <= 1'b0;
          end else begin
            j <= j + 1'b1;
          end
        end else begin
          pc <= pc + 1'b1;
        end
      end
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pc <= bpt_pkg::LAST_PC)
    else $error("program counter past last step");

  a_j_range: assert property (@(posedge clk) disable iff (rst)
    j <= bpt_pkg::J_W'(bpt_pkg::STEPS))
    else $error("sample index past end of segment");

  a_idle_pc: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (pc == '0))
    else $error("idle with program counter off step zero");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (advance && uw.emit && last_j) |=> (!busy && sample_valid && sample.last_sample))
    else $error("final sample did not end the segment");

  a_mid_not_last: assert property (@(posedge clk) disable iff (rst)
    (advance && uw.emit && !last_j) |=> (busy && !sample.last_sample))
    else $error("inner sample marked last");

endmodule

[sim/bezier_path_tessellator_tb.sv]
// Testbench for bezier_path_tessellator: drives knot beats, predicts every curve sample
// with its own de Casteljau model and checks each sample beat in order.
// Depends on bpt_pkg and the bezier_path_tessellator RTL.
module bezier_path_tessellator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEG_STEPS = bpt_pkg::STEPS;
  localparam int RANDOM_KNOTS = 300;

  logic             clk;
  logic             rst = 1'b1;
  logic             knot_valid = 1'b0;
  logic             knot_ready;
  bpt_pkg::knot_t   knot = '0;
  logic             sample_valid;
  logic             sample_ready = 1'b0;
  bpt_pkg::sample_t sample;

  bpt_pkg::sample_t   expected_samples[$];
  logic               path_open = 1'b0;
  logic signed [15:0] anchor_x = '0;
  logic signed [15:0] anchor_y = '0;
  logic signed [15:0] handle_x = '0;
  logic signed [15:0] handle_y = '0;
  int                 knot_count, segment_count, sample_count, error_count;
  int                 burst_left;
  int                 stall_mode = 0;
  logic [7:0]         stall_cyc = '0;

  bezier_path_tessellator uut (
    .clk(clk),
    .rst(rst),
    .knot_valid(knot_valid),
    .knot_ready(knot_ready),
    .knot(knot),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("%t timeout: %0d samples still outstanding", $time, expected_samples.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic signed [15:0] blend(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input longint t);
    longint acc;
    acc = longint'(a) * (longint'(65536) - t) + longint'(b) * t + longint'(32768);
    acc = acc >>> 16;
    if (acc > 32767) acc = 32767;
    else if (acc < -32768) acc = -32768;
    return 16'(acc);
  endfunction

  function automatic logic signed [15:0] bezier_at(input logic signed [15:0] p0,
                                                   input logic signed [15:0] p1,
                                                   input logic signed [15:0] p2,
                                                   input logic signed [15:0] p3,
                                                   input longint t);
    logic signed [15:0] b1, b2, b3, c1, c2;
    b1 = blend(p0, p1, t);
    b2 = blend(p1, p2, t);
    b3 = blend(p2, p3, t);
    c1 = blend(b1, b2, t);
    c2 = blend(b2, b3, t);
    return blend(c1, c2, t);
  endfunction

  function automatic void predict_knot(input bpt_pkg::knot_t k);
    bpt_pkg::sample_t s;
    longint           t;
    knot_count++;
    if (!k.first_point && path_open) begin
      segment_count++;
      for (int j = 0; j <= SEG_STEPS; j++) begin
        t = (longint'(j) * 2 * 65536 + SEG_STEPS) / (2 * SEG_STEPS);
        s.sample_x = bezier_at(anchor_x, handle_x, k.in_handle_x, k.knot_x, t);
        s.sample_y = bezier_at(anchor_y, handle_y, k.in_handle_y, k.knot_y, t);
        s.last_sample = (j == SEG_STEPS);
        expected_samples = {expected_samples, s};
      end
    end
    path_open = 1'b1;
    anchor_x = k.knot_x;
    anchor_y = k.knot_y;
    handle_x = k.out_handle_x;
    handle_y = k.out_handle_y;
  endfunction

  function automatic void check_sample(input bpt_pkg::sample_t got);
    bpt_pkg::sample_t want;
    if (expected_samples.size() == 0) begin
      $display("%t unexpected sample: expected none, got x=%0d y=%0d last=%0b",
               $time, got.sample_x, got.sample_y, got.last_sample);
      error_count++;
      return;
    end
    want = expected_samples.pop_front();
    sample_count++;
    if (got.sample_x !== want.sample_x) begin
      $display("%t sample_x mismatch: expected %0d, got %0d", $time, want.sample_x,
               got.sample_x);
      error_count++;
    end
    if (got.sample_y !== want.sample_y) begin
      $display("%t sample_y mismatch: expected %0d, got %0d", $time, want.sample_y,
               got.sample_y);
      error_count++;
    end
    if (got.last_sample !== want.last_sample) begin
      $display("%t last_sample mismatch: expected %0b, got %0b", $time, want.last_sample,
               got.last_sample);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_ready) check_sample(sample);
      if (knot_valid && knot_ready) predict_knot(knot);
    end
  end

  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 8'd1;
    if (stall_cyc == 8'd0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: sample_ready <= 1'b1;
      1: sample_ready <= ($urandom_range(0, 2) != 0);
      2: sample_ready <= (stall_cyc[3:0] < 4'd11);
      default: sample_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  function automatic bpt_pkg::knot_t make_knot(input logic fp,
                                               input logic signed [15:0] kx, ky, ix, iy,
                                                                         ox, oy);
    bpt_pkg::knot_t k;
    k.first_point = fp;
    k.knot_x = kx;
    k.knot_y = ky;
    k.in_handle_x = ix;
    k.in_handle_y = iy;
    k.out_handle_x = ox;
    k.out_handle_y = oy;
    return k;
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return 16'($signed($urandom_range(0, 4000)) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bpt_pkg::knot_t rand_knot(input logic fp);
    return make_knot(fp, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord());
  endfunction

  task automatic send_knot(input bpt_pkg::knot_t k);
    int idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 7))
        0, 1: idle = 0;
        2: idle = $urandom_range(40, 200);
        default: idle = $urandom_range(1, 40);
      endcase
      if (idle != 0) begin
        knot_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    knot_valid <= 1'b1;
    knot <= k;
    do @(posedge clk); while (!knot_ready);
  endtask

  task automatic wait_drained();
    knot_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic test_orphan_knot();
    send_knot(make_knot(1'b0, 16'sd160, -16'sd80, 16'sd0, 16'sd0, 16'sd320, 16'sd40));
    send_knot(make_knot(1'b0, 16'sd800, 16'sd480, 16'sd640, 16'sd560, 16'sd0, 16'sd0));
  endtask

  task automatic test_extreme_segments();
    send_knot(make_knot(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                        16'sh7fff, 16'sh7fff));
    send_knot(make_knot(1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                        16'sh8000, 16'sh8000));
    send_knot(make_knot(1'b0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                        16'sh7fff, 16'sh8000));
    send_knot(make_knot(1'b0, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
                        16'sh8000, 16'sh7fff));
    send_knot(make_knot(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
    send_knot(make_knot(1'b0, -16'sd1, 16'sd1, 16'sh5555, -16'sh5556, 16'sh2aaa, -16'sd1));
    send_knot(make_knot(1'b0, 16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd0, 16'sd0));
  endtask

  task automatic test_path_restart();
    send_knot(make_knot(1'b1, 16'sd100, 16'sd200, 16'sd50, 16'sd60, 16'sd300, 16'sd400));
    send_knot(make_knot(1'b1, -16'sd900, 16'sd700, 16'sd10, -16'sd10, -16'sd500, 16'sd900));
    send_knot(make_knot(1'b0, 16'sd1200, -16'sd300, 16'sd900, 16'sd100, 16'sd1500, 16'sd0));
    send_knot(make_knot(1'b1, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd5));
    send_knot(make_knot(1'b0, -16'sd2000, -16'sd2000, 16'sd3000, -16'sd3000,
                        16'sd0, 16'sd0));
  endtask

  task automatic test_drain_pause();
    send_knot(rand_knot(1'b1));
    repeat (3) send_knot(rand_knot(1'b0));
    wait_drained();
    send_knot(rand_knot(1'b0));
    send_knot(rand_knot(1'b0));
  endtask

  task automatic test_random_paths(input int total);
    int sent;
    int path_len;
    sent = 0;
    while (sent < total) begin
      path_len = $urandom_range(1, 12);
      for (int i = 0; i < path_len && sent < total; i++) begin
        if ($urandom_range(0, 9) == 0) send_knot(rand_knot(1'($urandom_range(0, 1))));
        else send_knot(rand_knot(i == 0));
        sent++;
      end
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
  endtask

  initial begin
    knot_count = 0;
    segment_count = 0;
    sample_count = 0;
    error_count = 0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_orphan_knot();
    test_extreme_segments();
    test_path_restart();
    test_drain_pause();
    test_random_paths(RANDOM_KNOTS);
    wait_drained();
    repeat (400) @(posedge clk);
    $display("Sent %0d knots forming %0d segments; checked %0d curve samples.",
             knot_count, segment_count, sample_count);
    $display("Covered orphan knots, path restarts, extreme coordinates and random paths.");
    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
